// ===== sv/nm33_pkg.sv =====
// Shared constants and helper functions for the 3x3 neighbour mean filter.
`default_nettype none

package nm33_pkg;

    localparam int MAX_WIDTH     = 32;
    localparam int MAX_HEIGHT    = 1024;
    localparam int PIXEL_BITS    = 8;
    localparam int FRACTION_BITS = 8;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int FW_W     = 6;
    localparam int FH_W     = 11;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W    = PIXEL_BITS + 3;
    localparam int CNT_W    = 4;
    localparam int MEAN_W   = 16;
    localparam int DIVD_W   = SUM_W + FRACTION_BITS;
    localparam int DCNT_W   = $clog2(DIVD_W);
    localparam int DEPTH    = 3 * MAX_WIDTH;
    localparam int ADDR_W   = $clog2(DEPTH);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Neighbour offset codes along one axis
    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    // Row offset of neighbour n, walked in raster order around the centre
    function automatic logic [1:0] nbr_dr(input logic [2:0] n);
        logic [1:0] code;
        case (n)
            3'd0, 3'd1, 3'd2: code = OFS_MINUS;
            3'd3, 3'd4:       code = OFS_ZERO;
            default:          code = OFS_PLUS;
        endcase
        return code;
    endfunction

    // Column offset of neighbour n
    function automatic logic [1:0] nbr_dc(input logic [2:0] n);
        logic [1:0] code;
        case (n)
            3'd0, 3'd3, 3'd5: code = OFS_MINUS;
            3'd1, 3'd6:       code = OFS_ZERO;
            default:          code = OFS_PLUS;
        endcase
        return code;
    endfunction

    // Line slots rotate modulo three
    function automatic logic [1:0] slot_inc(input logic [1:0] s);
        return (s == 2'd2) ? 2'd0 : s + 2'd1;
    endfunction

    function automatic logic [1:0] slot_dec(input logic [1:0] s);
        return (s == 2'd0) ? 2'd2 : s - 2'd1;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0] s,
                                                     input logic [COL_W-1:0] c);
        return ADDR_W'(s) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== sv/neighbour_mean_3x3_top.sv =====
// Top level of the 3x3 neighbour mean filter: line store, sequencer and divider.
//
// Usage: pixels enter in raster order on the in_valid/in_ready channel; each
// transfer writes the pixel into a three-row line store. Results leave on the
// out_valid/out_ready channel, one transfer per result, with the in-frame
// neighbour sum and count, the position, last_in_run and end_of_frame.
// Frame size is set through cfg_we/cfg_index/cfg_data (index 0 width, index 1
// height); a write to either of them restarts the frame at position (0, 0).
// Steps: each result takes 8 line store reads through the single read port, a
// step to collect the last read, the bit-serial divider and a load of the
// output register. No new pixel is taken until the last result of the current
// pixel has been loaded; the last pixel of a frame yields up to width + 2 results.
// Reset: position returns to (0, 0), width and height to 10. The line store is
// not cleared; only pixels of the current frame are ever read.
// Stall: the output register holds a result until it is taken; a new pixel is
// taken while the last result of the previous one still waits, and the next
// result waits in the sequencer until the output register frees up.
`default_nettype none

module neighbour_mean_3x3_top
    import nm33_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            pixel,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [MEAN_W-1:0]          mean_fixed,
    output logic [SUM_W-1:0]           neighbour_sum,
    output logic [CNT_W-1:0]           neighbour_count,
    output logic [ROW_W-1:0]           out_row,
    output logic [COL_W-1:0]           out_col,
    output logic                       last_in_run,
    output logic                       end_of_frame
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // Which result of a run is being worked on
    localparam logic [1:0] PH_A = 2'd0;   // diagonal-behind position
    localparam logic [1:0] PH_B = 2'd1;   // end of the previous row
    localparam logic [1:0] PH_C = 2'd2;   // flush of the last row

    logic [2:0]        state_reg;
    logic [ROW_W-1:0]  row_pos_reg;
    logic [COL_W-1:0]  col_pos_reg;
    logic [1:0]        slot_pos_reg;
    logic [COL_W-1:0]  wm1_reg;
    logic [ROW_W-1:0]  hm1_reg;
    logic              out_valid_reg;
    logic              rd_pend_reg;

    logic [ROW_W-1:0]  run_row_reg;
    logic [1:0]        run_slot_reg;
    logic              has_b_reg;
    logic              has_c_reg;
    logic [1:0]        phase_reg;
    logic [ROW_W-1:0]  res_row_reg;
    logic [COL_W-1:0]  res_col_reg;
    logic [1:0]        res_slot_reg;
    logic [2:0]        nbr_idx_reg;
    logic [SUM_W-1:0]  acc_sum_reg;
    logic [CNT_W-1:0]  acc_cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] div_cnt_reg;

    logic [MEAN_W-1:0] mean_reg;
    logic [SUM_W-1:0]  sum_out_reg;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic [ROW_W-1:0]  row_out_reg;
    logic [COL_W-1:0]  col_out_reg;
    logic              last_out_reg;
    logic              eof_out_reg;

    logic [PIXEL_BITS-1:0] line_mem [DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;

    logic accept;
    logic cur_has_a, cur_has_b, cur_has_c;
    logic [1:0] dr, dc;
    logic nbr_in_frame;
    logic [1:0] nbr_slot;
    logic [COL_W-1:0] nbr_col;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [SUM_W-1:0] sum_final;
    logic [CNT_W-1:0] cnt_final;
    logic [CNT_W:0] div_trial, div_sub;
    logic div_ge;
    logic emit_load;
    logic nxt_valid;
    logic [1:0] nxt_phase;
    logic [ROW_W-1:0] nxt_row;
    logic [COL_W-1:0] nxt_col;
    logic [1:0] nxt_slot;
    logic [FW_W-1:0] cfg_w;
    logic [FH_W-1:0] cfg_h;
    logic [FW_W-1:0] w_clamp;
    logic [FH_W-1:0] h_clamp;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    assign cur_has_a = (row_pos_reg != '0) && (col_pos_reg != '0);
    assign cur_has_b = (row_pos_reg != '0) && (col_pos_reg == wm1_reg);
    assign cur_has_c = (row_pos_reg == hm1_reg) && (col_pos_reg == wm1_reg);

    // Clamp the register values into the meaningful frame size
    assign cfg_w = cfg_data[FW_W-1:0];
    assign cfg_h = cfg_data[FH_W-1:0];
    always_comb
    begin
        w_clamp = cfg_w;
        if (cfg_w < FW_W'(2))
        begin
            w_clamp = FW_W'(2);
        end
        else if (cfg_w > FW_W'(MAX_WIDTH))
        begin
            w_clamp = FW_W'(MAX_WIDTH);
        end
        h_clamp = cfg_h;
        if (cfg_h < FH_W'(2))
        begin
            h_clamp = FH_W'(2);
        end
        else if (cfg_h > FH_W'(MAX_HEIGHT))
        begin
            h_clamp = FH_W'(MAX_HEIGHT);
        end
    end

    // Neighbour address for the current read step
    assign dr = nbr_dr(nbr_idx_reg);
    assign dc = nbr_dc(nbr_idx_reg);

    always_comb
    begin
        nbr_in_frame = 1'b1;
        nbr_slot     = res_slot_reg;
        nbr_col      = res_col_reg;
        case (dr)
            OFS_MINUS:
            begin
                nbr_slot = slot_dec(res_slot_reg);
                if (res_row_reg == '0)
                begin
                    nbr_in_frame = 1'b0;
                end
            end
            OFS_PLUS:
            begin
                nbr_slot = slot_inc(res_slot_reg);
                if (res_row_reg == hm1_reg)
                begin
                    nbr_in_frame = 1'b0;
                end
            end
            default: ;
        endcase
        case (dc)
            OFS_MINUS:
            begin
                nbr_col = res_col_reg - COL_W'(1);
                if (res_col_reg == '0)
                begin
                    nbr_in_frame = 1'b0;
                end
            end
            OFS_PLUS:
            begin
                nbr_col = res_col_reg + COL_W'(1);
                if (res_col_reg == wm1_reg)
                begin
                    nbr_in_frame = 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign rd_addr = store_addr(nbr_slot, nbr_col);
    assign wr_addr = store_addr(slot_pos_reg, col_pos_reg);

    // Line store: one write port for incoming pixels, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[wr_addr] <= pixel[PIXEL_BITS-1:0];
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    // Sum and count including the read still in flight
    assign sum_final = acc_sum_reg + (rd_pend_reg ? SUM_W'(rd_data_reg) : '0);
    assign cnt_final = acc_cnt_reg + (rd_pend_reg ? CNT_W'(1) : '0);

    // One quotient bit per cycle, restoring
    assign div_trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, acc_cnt_reg});
    assign div_sub   = div_trial - {1'b0, acc_cnt_reg};

    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    // Next result of the current run
    always_comb
    begin
        nxt_valid = 1'b0;
        nxt_phase = phase_reg;
        nxt_row   = res_row_reg;
        nxt_col   = res_col_reg;
        nxt_slot  = res_slot_reg;
        case (phase_reg)
            PH_A:
            begin
                if (has_b_reg)
                begin
                    nxt_valid = 1'b1;
                    nxt_phase = PH_B;
                    nxt_col   = wm1_reg;
                end
                else if (has_c_reg)
                begin
                    nxt_valid = 1'b1;
                    nxt_phase = PH_C;
                    nxt_row   = run_row_reg;
                    nxt_slot  = run_slot_reg;
                    nxt_col   = '0;
                end
            end
            PH_B:
            begin
                if (has_c_reg)
                begin
                    nxt_valid = 1'b1;
                    nxt_phase = PH_C;
                    nxt_row   = run_row_reg;
                    nxt_slot  = run_slot_reg;
                    nxt_col   = '0;
                end
            end
            PH_C:
            begin
                if (res_col_reg != wm1_reg)
                begin
                    nxt_valid = 1'b1;
                    nxt_col   = res_col_reg + COL_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            slot_pos_reg  <= '0;
            wm1_reg       <= COL_W'(9);
            hm1_reg       <= ROW_W'(9);
            out_valid_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= (state_reg == ST_READ) && nbr_in_frame;

            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Writes to the width or height register restart the frame; the store keeps its data
            if (cfg_we && (cfg_index == REG_FRAME_WIDTH))
            begin
                wm1_reg      <= COL_W'(w_clamp - FW_W'(1));
                row_pos_reg  <= '0;
                col_pos_reg  <= '0;
                slot_pos_reg <= '0;
            end
            else if (cfg_we && (cfg_index == REG_FRAME_HEIGHT))
            begin
                hm1_reg      <= ROW_W'(h_clamp - FH_W'(1));
                row_pos_reg  <= '0;
                col_pos_reg  <= '0;
                slot_pos_reg <= '0;
            end
            else if (accept)
            begin
                // Advance the raster position
                if (col_pos_reg != wm1_reg)
                begin
                    col_pos_reg <= col_pos_reg + COL_W'(1);
                end
                else
                begin
                    col_pos_reg <= '0;
                    if (row_pos_reg != hm1_reg)
                    begin
                        row_pos_reg  <= row_pos_reg + ROW_W'(1);
                        slot_pos_reg <= slot_inc(slot_pos_reg);
                    end
                    else
                    begin
                        row_pos_reg  <= '0;
                        slot_pos_reg <= '0;
                    end
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (cur_has_a || cur_has_b || cur_has_c))
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (nbr_idx_reg == 3'd7)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        state_reg <= nxt_valid ? ST_READ : ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    run_row_reg  <= row_pos_reg;
                    run_slot_reg <= slot_pos_reg;
                    has_b_reg    <= cur_has_b;
                    has_c_reg    <= cur_has_c;
                    nbr_idx_reg  <= '0;
                    acc_sum_reg  <= '0;
                    acc_cnt_reg  <= '0;
                    // Pick the first result of the run
                    if (cur_has_a)
                    begin
                        phase_reg    <= PH_A;
                        res_row_reg  <= row_pos_reg - ROW_W'(1);
                        res_col_reg  <= col_pos_reg - COL_W'(1);
                        res_slot_reg <= slot_dec(slot_pos_reg);
                    end
                    else if (cur_has_b)
                    begin
                        phase_reg    <= PH_B;
                        res_row_reg  <= row_pos_reg - ROW_W'(1);
                        res_col_reg  <= wm1_reg;
                        res_slot_reg <= slot_dec(slot_pos_reg);
                    end
                    else
                    begin
                        phase_reg    <= PH_C;
                        res_row_reg  <= row_pos_reg;
                        res_col_reg  <= '0;
                        res_slot_reg <= slot_pos_reg;
                    end
                end
            end
            ST_READ:
            begin
                nbr_idx_reg <= nbr_idx_reg + 3'd1;
                acc_sum_reg <= sum_final;
                acc_cnt_reg <= cnt_final;
            end
            ST_DRAIN:
            begin
                acc_sum_reg <= sum_final;
                acc_cnt_reg <= cnt_final;
                quo_reg     <= DIVD_W'(sum_final) << FRACTION_BITS;
                rem_reg     <= '0;
                div_cnt_reg <= DCNT_W'(DIVD_W - 1);
            end
            ST_DIV:
            begin
                quo_reg     <= {quo_reg[DIVD_W-2:0], div_ge};
                rem_reg     <= div_ge ? div_sub[CNT_W-1:0] : div_trial[CNT_W-1:0];
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    mean_reg     <= quo_reg[MEAN_W-1:0];
                    sum_out_reg  <= acc_sum_reg;
                    cnt_out_reg  <= acc_cnt_reg;
                    row_out_reg  <= res_row_reg;
                    col_out_reg  <= res_col_reg;
                    last_out_reg <= !nxt_valid;
                    eof_out_reg  <= (res_row_reg == hm1_reg) && (res_col_reg == wm1_reg);
                    // Move on to the next result of the run
                    phase_reg    <= nxt_phase;
                    res_row_reg  <= nxt_row;
                    res_col_reg  <= nxt_col;
                    res_slot_reg <= nxt_slot;
                    nbr_idx_reg  <= '0;
                    acc_sum_reg  <= '0;
                    acc_cnt_reg  <= '0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign mean_fixed      = mean_reg;
    assign neighbour_sum   = sum_out_reg;
    assign neighbour_count = cnt_out_reg;
    assign out_row         = row_out_reg;
    assign out_col         = col_out_reg;
    assign last_in_run     = last_out_reg;
    assign end_of_frame    = eof_out_reg;

`ifndef SYNTH
    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (neighbour_count == CNT_W'(3) || neighbour_count == CNT_W'(5)
                       || neighbour_count == CNT_W'(8)))
        else $error("neighbour count is not 3, 5 or 8");

    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_frame) |-> last_in_run)
        else $error("frame end result is not last of its run");

    a_read_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && nbr_idx_reg == 3'd7) |=> (state_reg == ST_DRAIN))
        else $error("read sweep did not end after eight neighbours");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_cnt_reg == '0) |=> (state_reg == ST_EMIT))
        else $error("divider did not hand over to emit");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input ready while a run is in progress");
`endif

endmodule

`default_nettype wire
